@@ hdl/esc_pkg.sv @@
// Shared types, constants and register codes for the sensor compensation pipeline.
// No dependencies; every other file imports this package.
`default_nettype none
package esc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned NUM_W = 64;
  localparam int unsigned DEN_W = 31;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned TF_W = 24;
  localparam int unsigned FRONT_LAT = 7;
  localparam int unsigned HUM_LAT = 13;
  localparam int unsigned PAD_LAT = HUM_LAT - FRONT_LAT;
  localparam int unsigned PRESS_W = 25;
  localparam int unsigned HUM_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP       = 3'd0,
    REG_PRESS_A    = 3'd1,
    REG_PRESS_B    = 3'd2,
    REG_PRESS_NINE = 3'd3,
    REG_HUM        = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0] adc_pressure;
    logic [19:0] adc_temperature;
    logic [15:0] adc_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  temperature_centi;
    logic [PRESS_W-1:0]  pressure_q8;
    logic [HUM_W-1:0]    humidity_q10;
    logic                pressure_invalid;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } coef_t;

  typedef struct packed {
    logic                  vld;
    logic signed [TF_W-1:0] tf;
    logic [19:0]           ap;
    logic [15:0]           ah;
  } fine_t;

  typedef struct packed {
    logic                    vld;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } front_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [HUM_W-1:0]   hum;
  } side_t;

  typedef struct packed {
    logic  vld;
    side_t side;
  } hum_t;

  typedef struct packed {
    logic                    vld;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    side_t                   side;
  } div_in_t;

  typedef struct packed {
    logic                    vld;
    logic signed [NUM_W-1:0] quot;
    logic                    zero;
    side_t                   side;
  } quot_t;

endpackage
`default_nettype wire

@@ hdl/environmental_sensor_compensation_unit.sv @@
// Top level of the sensor compensation pipeline: configuration registers and stage chain.
// Depends on esc_pkg, esc_fine_temp, esc_hum, esc_press_front, esc_div, esc_press_back.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 temperature, 1 and 2 pressure
//   groups, 3 pressure P9, 4 humidity) and cfg_data. cfg_ready is always high; writes to
//   other indexes are dropped. Write only while no transaction is in flight.
//   Command: a transaction is taken at each edge where start is high and busy low.
//   busy stays low, so one raw measurement may enter every cycle.
//   Result: done is high for one cycle with the compensated values on result.
//   Throughput is one result per cycle. Each item passes through the t_fine and humidity
//   stages and then the 64-stage divider, one quotient bit per stage.
//   The receiver cannot stall: every result is shown exactly once.
//   Reset (rst, synchronous) clears all coefficients to zero and empties the pipeline;
//   no clearing pass is needed.
`default_nettype none
module environmental_sensor_compensation_unit import esc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              cmd,
  output logic                       done,
  output out_item_t                  result
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_a;
  logic [63:0] press_coeffs_b;
  logic [15:0] press_coeff_nine;
  logic [63:0] hum_coeffs;
  coef_t  coef;
  fine_t  fine;
  hum_t   hum;
  front_t front;
  front_t pad_line [PAD_LAT];
  div_in_t din;
  quot_t  quot;

  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs      <= '0;
      press_coeffs_a   <= '0;
      press_coeffs_b   <= '0;
      press_coeff_nine <= '0;
      hum_coeffs       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEMP:       temp_coeffs      <= cfg_data[47:0];
        REG_PRESS_A:    press_coeffs_a   <= cfg_data;
        REG_PRESS_B:    press_coeffs_b   <= cfg_data;
        REG_PRESS_NINE: press_coeff_nine <= cfg_data[15:0];
        REG_HUM:        hum_coeffs       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.t1 = temp_coeffs[15:0];
    coef.t2 = temp_coeffs[31:16];
    coef.t3 = temp_coeffs[47:32];
    coef.p1 = press_coeffs_a[15:0];
    coef.p2 = press_coeffs_a[31:16];
    coef.p3 = press_coeffs_a[47:32];
    coef.p4 = press_coeffs_a[63:48];
    coef.p5 = press_coeffs_b[15:0];
    coef.p6 = press_coeffs_b[31:16];
    coef.p7 = press_coeffs_b[47:32];
    coef.p8 = press_coeffs_b[63:48];
    coef.p9 = press_coeff_nine;
    coef.h1 = hum_coeffs[7:0];
    coef.h2 = hum_coeffs[23:8];
    coef.h3 = hum_coeffs[31:24];
    coef.h4 = hum_coeffs[43:32];
    coef.h5 = hum_coeffs[55:44];
    coef.h6 = hum_coeffs[63:56];
  end

  esc_fine_temp u_fine (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start && !busy),
    .in_item (cmd),
    .coef    (coef),
    .fine    (fine)
  );

  esc_hum u_hum (
    .clk  (clk),
    .rst  (rst),
    .fine (fine),
    .coef (coef),
    .hum  (hum)
  );

  esc_press_front u_front (
    .clk   (clk),
    .rst   (rst),
    .fine  (fine),
    .coef  (coef),
    .front (front)
  );

  // align pressure front with the longer humidity path
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAD_LAT; i++) begin
        pad_line[i].vld <= 1'b0;
      end
    end else begin
      pad_line[0] <= front;
      for (int i = 1; i < PAD_LAT; i++) begin
        pad_line[i] <= pad_line[i-1];
      end
    end
  end

  assign din = '{vld: pad_line[PAD_LAT-1].vld && hum.vld,
                 num: pad_line[PAD_LAT-1].num,
                 den: pad_line[PAD_LAT-1].den,
                 side: hum.side};

  esc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (quot)
  );

  esc_press_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qin    (quot),
    .coef   (coef),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

@@ hdl/esc_fine_temp.sv @@
// Fine-temperature stages: four registers from raw codes to t_fine.
// Depends on esc_pkg.
`default_nettype none
module esc_fine_temp import esc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_vld,
  input  wire in_item_t in_item,
  input  wire coef_t    coef,
  output fine_t         fine
);

  logic [3:0] vld;
  logic [19:0] ap1, ap2, ap3;
  logic [15:0] ah1, ah2, ah3;
  logic signed [18:0] d1;
  logic signed [17:0] d2;
  logic signed [34:0] m1;
  logic signed [35:0] sq;
  logic signed [22:0] v1;
  logic signed [39:0] pr;
  logic signed [TF_W-1:0] tf;
  logic [19:0] ap4;
  logic [15:0] ah4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    d1  <= $signed({2'b00, in_item.adc_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
    d2  <= 18'($signed({2'b00, in_item.adc_temperature[19:4]}) - $signed({1'b0, coef.t1}));
    ap1 <= in_item.adc_pressure;
    ah1 <= in_item.adc_humidity;
    m1  <= d1 * coef.t2;
    sq  <= d2 * d2;
    ap2 <= ap1;
    ah2 <= ah1;
    v1  <= 23'(m1 >>> 11);
    pr  <= 40'(sq >>> 12) * 40'(coef.t3);
    ap3 <= ap2;
    ah3 <= ah2;
    tf  <= TF_W'(v1 + TF_W'(pr >>> 14));
    ap4 <= ap3;
    ah4 <= ah3;
  end

  assign fine = '{vld: vld[3], tf: tf, ap: ap4, ah: ah4};

endmodule
`default_nettype wire

@@ hdl/esc_hum.sv @@
// Humidity stages and temperature output formatting, thirteen registers from t_fine.
// Depends on esc_pkg.
`default_nettype none
module esc_hum import esc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire fine_t fine,
  input  wire coef_t coef,
  output hum_t       hum
);

  logic [HUM_LAT-1:0] vld;
  logic signed [15:0] temp [HUM_LAT-1];
  logic signed [27:0] t5;
  logic signed [19:0] t8;
  logic signed [15:0] tsat;
  side_t side_q;

  logic signed [24:0] x;
  logic [15:0] ah1, ah2;
  logic signed [36:0] m5;
  logic signed [32:0] m6;
  logic signed [33:0] m3;
  logic signed [39:0] asum;
  logic signed [23:0] a3, a4, a5, a6, a7;
  logic signed [22:0] c6;
  logic signed [23:0] c3;
  logic signed [46:0] bp;
  logic signed [37:0] b0;
  logic signed [53:0] bm;
  logic signed [40:0] b;
  logic signed [63:0] xh8, xh9, xh10, xh11, xh12;
  logic signed [63:0] y;
  logic [63:0] pl;
  logic [31:0] pc;
  logic signed [63:0] yy;
  logic signed [63:0] t12;
  logic signed [63:0] r;
  logic [HUM_W-1:0] hq;

  assign t5 = 28'(fine.tf) * 28'sd5 + 28'sd128;
  assign t8 = 20'(t5 >>> 8);
  assign tsat = (t8 > 20'sd32767) ? 16'sh7fff :
                (t8 < -20'sd32768) ? 16'sh8000 : t8[15:0];

  assign asum = 40'($signed({1'b0, ah2, 14'd0})) - (40'(coef.h4) <<< 20) - 40'(m5)
              + 40'sd16384;
  assign r = xh12 - (t12 >>> 4);

  always_comb begin
    if (r < 0) begin
      hq = '0;
    end else if (r > 64'sd419430400) begin
      hq = HUM_W'(64'd419430400 >> 12);
    end else begin
      hq = HUM_W'(r >>> 12);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[HUM_LAT-2:0], fine.vld};
    end
  end

  always_ff @(posedge clk) begin
    temp[0] <= tsat;
    for (int i = 1; i < HUM_LAT-1; i++) begin
      temp[i] <= temp[i-1];
    end
    x    <= 25'(fine.tf) - 25'sd76800;
    ah1  <= fine.ah;
    m5   <= x * coef.h5;
    m6   <= x * coef.h6;
    m3   <= x * $signed({1'b0, coef.h3});
    ah2  <= ah1;
    a3   <= 24'(asum >>> 15);
    c6   <= 23'(m6 >>> 10);
    c3   <= 24'(m3 >>> 11) + 24'sd32768;
    a4   <= a3;
    bp   <= c6 * c3;
    a5   <= a4;
    b0   <= 38'(bp >>> 10) + 38'sd2097152;
    a6   <= a5;
    bm   <= b0 * coef.h2;
    a7   <= a6;
    b    <= 41'((bm + 54'sd8192) >>> 14);
    xh8  <= 64'(a7) * 64'(b);
    xh9  <= xh8;
    y    <= xh8 >>> 15;
    xh10 <= xh9;
    pl   <= y[31:0] * y[31:0];
    pc   <= y[31:0] * y[63:32];
    xh11 <= xh10;
    yy   <= $signed(pl + {pc[30:0], 33'd0});
    xh12 <= xh11;
    t12  <= (yy >>> 7) * 64'($signed({1'b0, coef.h1}));
    side_q.hum  <= hq;
    side_q.temp <= temp[HUM_LAT-2];
  end

  assign hum = '{vld: vld[HUM_LAT-1], side: side_q};

endmodule
`default_nettype wire

@@ hdl/esc_press_front.sv @@
// Pressure front stages: numerator and divisor of the pressure quotient, seven registers.
// Depends on esc_pkg.
`default_nettype none
module esc_press_front import esc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire fine_t fine,
  input  wire coef_t coef,
  output front_t     front
);

  logic [FRONT_LAT-1:0] vld;
  logic signed [24:0] pv;
  logic [20:0] pp1, pp2, pp3, pp4;
  logic signed [49:0] sq;
  logic signed [39:0] m5, m2, m5b, m2b;
  logic signed [63:0] a6, a3;
  logic signed [63:0] v2, v1b;
  logic signed [63:0] nump, s47;
  logic signed [63:0] num6, num7;
  logic signed [63:0] dprod;
  logic signed [DEN_W-1:0] den;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LAT-2:0], fine.vld};
    end
  end

  always_ff @(posedge clk) begin
    pv    <= 25'(fine.tf) - 25'sd128000;
    pp1   <= 21'd1048576 - 21'(fine.ap);
    sq    <= pv * pv;
    m5    <= pv * coef.p5;
    m2    <= pv * coef.p2;
    pp2   <= pp1;
    a6    <= 64'(sq) * 64'(coef.p6);
    a3    <= 64'(sq) * 64'(coef.p3);
    m5b   <= m5;
    m2b   <= m2;
    pp3   <= pp2;
    v2    <= a6 + (64'(m5b) <<< 17) + (64'(coef.p4) <<< 35);
    v1b   <= (a3 >>> 8) + (64'(m2b) <<< 12);
    pp4   <= pp3;
    nump  <= $signed({12'd0, pp4, 31'd0}) - v2;
    s47   <= v1b + (64'sd1 <<< 47);
    num6  <= nump * 64'sd3125;
    dprod <= s47 * 64'($signed({1'b0, coef.p1}));
    num7  <= num6;
    den   <= $signed(dprod[63:33]);
  end

  assign front = '{vld: vld[FRONT_LAT-1], num: num7, den: den};

endmodule
`default_nettype wire

@@ hdl/esc_div.sv @@
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Depends on esc_pkg; carries the item's side fields along with the quotient.
`default_nettype none
module esc_div import esc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire div_in_t din,
  output quot_t        dout
);

  typedef struct packed {
    logic             vld;
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             zero;
    side_t            side;
  } step_t;

  function automatic step_t div_step(step_t s);
    step_t r;
    logic [DEN_W:0] trial;
    logic qb;
    r = s;
    trial = {s.rem, s.nq[NUM_W-1]};
    qb = (trial >= {1'b0, s.den});
    if (qb) begin
      r.rem = DEN_W'(trial - {1'b0, s.den});
    end else begin
      r.rem = trial[DEN_W-1:0];
    end
    r.nq = {s.nq[NUM_W-2:0], qb};
    return r;
  endfunction

  step_t stg [DIV_STEPS+1];
  logic [NUM_W-1:0] num_abs;
  logic [DEN_W-1:0] den_abs;

  assign num_abs = din.num[NUM_W-1] ? (~din.num + 1'b1) : din.num;
  assign den_abs = din.den[DEN_W-1] ? (~din.den + 1'b1) : din.den;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        stg[i].vld <= 1'b0;
      end
      dout.vld <= 1'b0;
    end else begin
      stg[0] <= '{vld: din.vld, nq: num_abs, rem: '0, den: den_abs,
                  neg: din.num[NUM_W-1] ^ din.den[DEN_W-1], zero: (din.den == '0),
                  side: din.side};
      for (int i = 0; i < DIV_STEPS; i++) begin
        stg[i+1] <= div_step(stg[i]);
      end
      dout.vld  <= stg[DIV_STEPS].vld;
      dout.quot <= stg[DIV_STEPS].neg ? $signed(~stg[DIV_STEPS].nq + 1'b1)
                                      : $signed(stg[DIV_STEPS].nq);
      dout.zero <= stg[DIV_STEPS].zero;
      dout.side <= stg[DIV_STEPS].side;
    end
  end

endmodule
`default_nettype wire

@@ hdl/esc_press_back.sv @@
// Pressure back stages: quotient correction terms, clamp and result register, five stages.
// Depends on esc_pkg.
`default_nettype none
module esc_press_back import esc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire quot_t qin,
  input  wire coef_t coef,
  output logic       done,
  output out_item_t  result
);

  logic [3:0] vld;
  logic [3:0] zero;
  side_t side [4];
  logic signed [63:0] x;
  logic signed [63:0] p1, p2, p3;
  logic [63:0] pl;
  logic [31:0] pc;
  logic signed [63:0] m8, b2, b3;
  logic signed [63:0] sq;
  logic signed [63:0] a9;
  logic signed [63:0] s4;
  logic signed [63:0] pr;
  logic [PRESS_W-1:0] pq;

  assign x  = qin.quot >>> 13;
  assign pr = (s4 >>> 8) + (64'(coef.p7) <<< 4);

  always_comb begin
    if (zero[3] || pr < 0) begin
      pq = '0;
    end else if (pr > 64'sd33554431) begin
      pq = '1;
    end else begin
      pq = pr[PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[2:0], qin.vld};
      done <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    zero    <= {zero[2:0], qin.zero};
    side[0] <= qin.side;
    for (int i = 1; i < 4; i++) begin
      side[i] <= side[i-1];
    end
    pl <= x[31:0] * x[31:0];
    pc <= x[31:0] * x[63:32];
    m8 <= 64'(coef.p8) * qin.quot;
    p1 <= qin.quot;
    sq <= $signed(pl + {pc[30:0], 33'd0});
    b2 <= m8 >>> 19;
    p2 <= p1;
    a9 <= 64'(coef.p9) * sq;
    b3 <= b2;
    p3 <= p2;
    s4 <= p3 + (a9 >>> 25) + b3;
    result.temperature_centi <= side[3].temp;
    result.humidity_q10      <= side[3].hum;
    result.pressure_q8       <= pq;
    result.pressure_invalid  <= zero[3];
  end

endmodule
`default_nettype wire

@@ bench/tb_environmental_sensor_compensation_unit.sv @@
// Testbench for environmental_sensor_compensation_unit: drives raw measurements and
// coefficient sets, predicts each compensated result and checks it. Depends on esc_pkg.
`default_nettype none
module tb_environmental_sensor_compensation_unit;
  import esc_pkg::*;

  class comp_scoreboard;
    logic [47:0] temp_c;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [15:0] press_nine;
    logic [63:0] hum_c;
    out_item_t   pending[$];
    int          mismatches;

    function new();
      temp_c = '0;
      press_a = '0;
      press_b = '0;
      press_nine = '0;
      hum_c = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [63:0] val);
      case (idx)
        REG_TEMP:       temp_c = val[47:0];
        REG_PRESS_A:    press_a = val;
        REG_PRESS_B:    press_b = val;
        REG_PRESS_NINE: press_nine = val[15:0];
        REG_HUM:        hum_c = val;
        default: ;
      endcase
    endfunction

    static function logic [63:0] asr(logic [63:0] v, int n);
      return $signed(v) >>> n;
    endfunction

    static function logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    static function logic [63:0] sx12(logic [11:0] v);
      return {{52{v[11]}}, v};
    endfunction

    static function logic [63:0] quot_tz(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
    endfunction

    function out_item_t compensate(in_item_t it);
      logic [63:0] ap, at, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] h1, h2, h3, h4, h5, h6;
      logic [63:0] d, v1, v2, tf, p, x, a, b, y, s;
      out_item_t r;
      ap = 64'(it.adc_pressure);
      at = 64'(it.adc_temperature);
      ah = 64'(it.adc_humidity);
      t1 = 64'(temp_c[15:0]);
      t2 = sx16(temp_c[31:16]);
      t3 = sx16(temp_c[47:32]);
      p1 = 64'(press_a[15:0]);
      p2 = sx16(press_a[31:16]);
      p3 = sx16(press_a[47:32]);
      p4 = sx16(press_a[63:48]);
      p5 = sx16(press_b[15:0]);
      p6 = sx16(press_b[31:16]);
      p7 = sx16(press_b[47:32]);
      p8 = sx16(press_b[63:48]);
      p9 = sx16(press_nine);
      h1 = 64'(hum_c[7:0]);
      h2 = sx16(hum_c[23:8]);
      h3 = 64'(hum_c[31:24]);
      h4 = sx12(hum_c[43:32]);
      h5 = sx12(hum_c[55:44]);
      h6 = {{56{hum_c[63]}}, hum_c[63:56]};
      r = '0;

      d = (at >> 3) - (t1 << 1);
      v1 = asr(d * t2, 11);
      d = (at >> 4) - t1;
      v2 = asr(asr(d * d, 12) * t3, 14);
      tf = v1 + v2;
      s = asr(tf * 64'd5 + 64'd128, 8);
      if ($signed(s) > 64'sd32767) s = 64'd32767;
      if ($signed(s) < -64'sd32768) s = -64'd32768;
      r.temperature_centi = s[15:0];

      v1 = tf - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr(((64'd1 << 47) + v1) * p1, 33);
      if (v1 == 64'd0) begin
        r.pressure_q8 = '0;
        r.pressure_invalid = 1'b1;
      end else begin
        p = 64'd1048576 - ap;
        p = quot_tz(((p << 31) - v2) * 64'd3125, v1);
        x = asr(p, 13);
        a = asr(p9 * x * x, 25);
        b = asr(p8 * p, 19);
        p = asr(p + a + b, 8) + (p7 << 4);
        if ($signed(p) < 0) p = 64'd0;
        if ($signed(p) > 64'sd33554431) p = 64'd33554431;
        r.pressure_q8 = p[24:0];
      end

      x = tf - 64'd76800;
      a = asr((ah << 14) - (h4 << 20) - h5 * x + 64'd16384, 15);
      b = asr(asr(x * h6, 10) * (asr(x * h3, 11) + 64'd32768), 10) + 64'd2097152;
      b = asr(b * h2 + 64'd8192, 14);
      x = a * b;
      y = asr(x, 15);
      x = x - asr(asr(y * y, 7) * h1, 4);
      if ($signed(x) < 0) x = 64'd0;
      if ($signed(x) > 64'sd419430400) x = 64'd419430400;
      r.humidity_q10 = x[28:12];
      return r;
    endfunction

    function void note_item(in_item_t it);
      pending.push_back(compensate(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.temperature_centi !== want.temperature_centi ||
          got.pressure_q8 !== want.pressure_q8 ||
          got.humidity_q10 !== want.humidity_q10 ||
          got.pressure_invalid !== want.pressure_invalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp t=%0d p=%0d h=%0d inv=%0b got t=%0d p=%0d h=%0d inv=%0b",
                   want.temperature_centi, want.pressure_q8, want.humidity_q10,
                   want.pressure_invalid, got.temperature_centi, got.pressure_q8,
                   got.humidity_q10, got.pressure_invalid);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  start;
  logic                  busy;
  in_item_t              cmd;
  logic                  done;
  out_item_t             result;

  comp_scoreboard sb;
  int             quiet_cycles;

  environmental_sensor_compensation_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_coeffs(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                             logic [63:0] p9, logic [63:0] h);
    write_reg(REG_TEMP, t);
    write_reg(REG_PRESS_A, pa);
    write_reg(REG_PRESS_B, pb);
    write_reg(REG_PRESS_NINE, p9);
    write_reg(REG_HUM, h);
  endtask

  task automatic send_item(in_item_t it, int idle_pct);
    start <= 1'b1;
    cmd <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    if ($urandom_range(99) < 75) begin
      it.adc_pressure = 20'($urandom_range(600000, 250000));
      it.adc_temperature = 20'($urandom_range(570000, 440000));
      it.adc_humidity = 16'($urandom_range(45000, 15000));
    end else begin
      it.adc_pressure = 20'($urandom);
      it.adc_temperature = 20'($urandom);
      it.adc_humidity = 16'($urandom);
    end
    return it;
  endfunction

  task automatic directed_items();
    in_item_t it;
    it = '0;
    send_item(it, 0);
    it = '1;
    send_item(it, 0);
    it = '{20'hFFFFF, 20'h00000, 16'hFFFF};
    send_item(it, 0);
    it = '{20'h00000, 20'hFFFFF, 16'h0000};
    send_item(it, 0);
    it = '{20'd415148, 20'd519888, 16'd30000};
    send_item(it, 0);
    it = '{20'h80000, 20'h80000, 16'h8000};
    send_item(it, 0);
    it = '{20'd1, 20'd1, 16'd1};
    send_item(it, 0);
  endtask

  task automatic random_phase(int n, int idle_pct);
    for (int i = 0; i < n; i++) begin
      if ((i / 40) % 3 == 2) send_item(rand_item(), 0);
      else send_item(rand_item(), idle_pct);
    end
    start <= 1'b0;
  endtask

  localparam logic [63:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PA = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_PB = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [63:0] TYP_P9 = 64'd6000;
  localparam logic [63:0] TYP_H  = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    cmd = '0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero coefficients: divisor is zero
    directed_items();
    start <= 1'b0;
    drain();

    load_coeffs(TYP_T, TYP_PA, TYP_PB, TYP_P9, TYP_H);
    directed_items();
    random_phase(240, 35);
    drain();

    load_coeffs('1, '1, '1, '1, '1);
    directed_items();
    start <= 1'b0;
    drain();

    load_coeffs({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 64'h8000,
                {8'h80, 12'h800, 12'h7FF, 8'hFF, 16'h8000, 8'hFF});
    directed_items();
    start <= 1'b0;
    drain();

    load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                64'($urandom), {$urandom, $urandom});
    random_phase(120, 45);
    drain();

    load_coeffs(TYP_T ^ 64'($urandom_range(255)), TYP_PA ^ 64'($urandom_range(255)),
                TYP_PB ^ 64'($urandom_range(255)), TYP_P9, TYP_H ^ 64'($urandom_range(255)));
    random_phase(130, 45);
    drain();

    load_coeffs(TYP_T, TYP_PA, TYP_PB, TYP_P9, TYP_H);
    random_phase(230, 0);
    drain();
    repeat (100) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
hdl/esc_pkg.sv
hdl/esc_fine_temp.sv
hdl/esc_hum.sv
hdl/esc_press_front.sv
hdl/esc_div.sv
hdl/esc_press_back.sv
hdl/environmental_sensor_compensation_unit.sv
bench/tb_environmental_sensor_compensation_unit.sv
